### hw/rtl/gde_pkg.sv
// Shared types, constants and helpers for the gyro detent encoder.
`timescale 1ns / 1ps

package gde_pkg;

   // Fixed-point format and scaling
   localparam int FRAC_BITS     = 16;
   localparam int GAIN_SHIFT    = 20;
   localparam int SCALE_SHIFT   = GAIN_SHIFT - FRAC_BITS;
   localparam int MAX_KEY_QUEUE = 32;
   localparam int MAX_RESULTS   = 30;
   localparam int PAIR_LIMIT    = MAX_KEY_QUEUE - 2;

   localparam int SUM_W  = 48;
   localparam int CNT_W  = 32;
   localparam int DIST_W = ((CNT_W + FRAC_BITS > SUM_W + 1) ?
                            (CNT_W + FRAC_BITS) : (SUM_W + 1)) + 1;
   localparam int ONE    = 1 << FRAC_BITS;
   localparam int HYST   = ONE + ONE / 4;

   // Emit bookkeeping
   localparam int STEP_CAP = MAX_RESULTS / 2;
   localparam int STEP_W   = $clog2(STEP_CAP + 1);
   localparam int N_W      = $clog2(MAX_RESULTS + 1);

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 48;
   localparam logic [CSR_ADDR_W-1:0] REG_GAIN_X    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_GAIN_Y    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_GAIN_Z    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_LOCK_EN   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_KEY_TABLE = 3'd4;

   // Direction codes and lock codes
   localparam logic [1:0] DIR_NONE  = 2'b00;
   localparam logic [1:0] DIR_POS   = 2'b01;
   localparam logic [1:0] DIR_NEG   = 2'b11;
   localparam logic [1:0] LOCK_NONE = 2'd0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL2,
      ST_ACC,
      ST_Q1,
      ST_Q2,
      ST_Q3,
      ST_LOCK,
      ST_CHK,
      ST_KEY,
      ST_REL
   } gde_state_type;

   typedef struct packed {
      logic accept;
      logic mul2;
      logic acc;
      logic q1;
      logic q2;
      logic q3;
      logic lock;
      logic load_key;
      logic load_rel;
   } gde_cmd_type;

   typedef struct packed {
      logic batch_end;
      logic pair_avail;
   } gde_status_type;

   // Saturate a sum one bit wider than the accumulator
   function automatic logic signed [SUM_W-1:0] sat48(input logic signed [SUM_W:0] v);
      logic signed [SUM_W-1:0] r;
      if (v[SUM_W] != v[SUM_W-1]) begin
         r = v[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         r = v[SUM_W-1:0];
      end
      return r;
   endfunction

endpackage

### hw/rtl/gde_ctrl.sv
// Sequencer for accumulate, quantize, lock and key emission.
`timescale 1ns / 1ps

module gde_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  gde_pkg::gde_status_type status,
   output gde_pkg::gde_cmd_type    cmd
);
   import gde_pkg::*;

   gde_state_type state_ff, state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_MUL2;
         ST_MUL2: state_in = ST_ACC;
         ST_ACC:  state_in = status.batch_end ? ST_Q1 : ST_IDLE;
         ST_Q1:   state_in = ST_Q2;
         ST_Q2:   state_in = ST_Q3;
         ST_Q3:   state_in = ST_LOCK;
         ST_LOCK: state_in = ST_CHK;
         ST_CHK:  state_in = status.pair_avail ? ST_KEY : ST_IDLE;
         ST_KEY:  if (rsp_ready) state_in = ST_REL;
         ST_REL:  if (rsp_ready) state_in = ST_CHK;
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands and handshake outputs
   always_comb begin
      cmd          = '0;
      req_ready    = (state_ff == ST_IDLE);
      rsp_valid    = (state_ff == ST_KEY) || (state_ff == ST_REL);
      cmd.accept   = (state_ff == ST_IDLE) && req_valid;
      cmd.mul2     = (state_ff == ST_MUL2);
      cmd.acc      = (state_ff == ST_ACC);
      cmd.q1       = (state_ff == ST_Q1);
      cmd.q2       = (state_ff == ST_Q2);
      cmd.q3       = (state_ff == ST_Q3);
      cmd.lock     = (state_ff == ST_LOCK);
      cmd.load_key = (state_ff == ST_CHK) && status.pair_avail;
      cmd.load_rel = (state_ff == ST_KEY) && rsp_ready;
   end

endmodule

### hw/rtl/gde_datapath.sv
// Three-lane multiply, accumulate, detent quantizer, axis lock and key selection.
`timescale 1ns / 1ps

module gde_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  gde_pkg::gde_cmd_type                  cmd,
   output gde_pkg::gde_status_type               status,
   input  logic                                  csr_wen,
   input  logic [gde_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  logic [gde_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic signed [15:0]                    req_rate_x,
   input  logic signed [15:0]                    req_rate_y,
   input  logic signed [15:0]                    req_rate_z,
   input  logic [15:0]                           req_interval_us,
   input  logic                                  req_batch_end,
   input  logic                                  req_restart,
   output logic [7:0]                            rsp_key_code,
   output logic                                  rsp_last
);
   import gde_pkg::*;

   // Configuration
   logic [15:0]           gain_ff [3];
   logic                  lock_en_ff;
   logic [CSR_DATA_W-1:0] key_table_ff;

   // Per-axis state
   logic signed [SUM_W-1:0]  batch_ff [3];
   logic signed [SUM_W-1:0]  total_ff [3];
   logic signed [CNT_W-1:0]  count_ff [3];
   logic [1:0]               first_ff [3];
   logic [1:0]               last_ff  [3];
   logic [1:0]               locked_ff;
   logic                     batch_end_ff;

   // Datapath registers
   logic [15:0]              interval_ff;
   logic signed [32:0]       prod1_ff [3];
   logic signed [SUM_W-1:0]  prod2_ff [3];
   logic signed [CNT_W-1:0]  cnt_ff   [3];
   logic signed [DIST_W-1:0] dist_ff  [3];
   logic [STEP_W-1:0]        steps_ff [3];
   logic                     pos_ff   [3];
   logic [N_W-1:0]           n_ff;
   logic [7:0]               key_ff;
   logic                     rlast_ff;

   // Combinational lane values
   logic signed [15:0]       rate       [3];
   logic                     active     [3];
   logic signed [32:0]       prod1_in   [3];
   logic signed [49:0]       prod2_wide [3];
   logic signed [SUM_W-1:0]  term       [3];
   logic signed [SUM_W-1:0]  acc_in     [3];
   logic signed [SUM_W-1:0]  tot_in     [3];
   logic signed [SUM_W:0]    curoff     [3];
   logic signed [SUM_W:0]    cnt_raw    [3];
   logic signed [CNT_W-1:0]  cnt_in     [3];
   logic signed [DIST_W-1:0] dist_in    [3];
   logic signed [CNT_W-1:0]  cntf_in    [3];
   logic signed [CNT_W:0]    diff_in    [3];
   logic [CNT_W:0]           absd       [3];
   logic [1:0]               dir_in     [3];
   logic [STEP_W-1:0]        steps_in   [3];
   logic [SUM_W-1:0]         mag        [3];
   logic [7:0]               key_of     [3];
   logic                     en         [3];
   logic                     hold;
   logic                     cnt_fits;
   logic [SUM_W-1:0]         mag_max;
   logic                     lock_hit;
   logic [1:0]               pick;
   logic [1:0]               sel;
   logic                     later_en;
   logic                     room_now;
   logic                     room_next;
   logic                     last_rel;

   assign rate[0] = req_rate_x;
   assign rate[1] = req_rate_y;
   assign rate[2] = req_rate_z;

   // Lane arithmetic
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         active[a]     = (locked_ff == LOCK_NONE) || (locked_ff == 2'(a + 1));
         prod1_in[a]   = rate[a] * $signed({1'b0, gain_ff[a]});
         prod2_wide[a] = prod1_ff[a] * $signed({1'b0, interval_ff});
         term[a]       = prod2_ff[a] >>> SCALE_SHIFT;
         acc_in[a]     = sat48({batch_ff[a][SUM_W-1], batch_ff[a]} +
                               {term[a][SUM_W-1], term[a]});
         tot_in[a]     = sat48({total_ff[a][SUM_W-1], total_ff[a]} +
                               {batch_ff[a][SUM_W-1], batch_ff[a]});

         // Ceiling offset when the first move was negative, or none yet and the total is negative
         if ((first_ff[a] == DIR_NONE && total_ff[a] < 0) || first_ff[a] == DIR_NEG) begin
            curoff[a] = {total_ff[a][SUM_W-1], total_ff[a]} + (SUM_W+1)'(ONE - 1);
         end else begin
            curoff[a] = {total_ff[a][SUM_W-1], total_ff[a]};
         end
         cnt_raw[a] = curoff[a] >>> FRAC_BITS;
         cnt_fits   = (&cnt_raw[a][SUM_W:CNT_W-1]) || !(|cnt_raw[a][SUM_W:CNT_W-1]);
         if (cnt_fits) begin
            cnt_in[a] = cnt_raw[a][CNT_W-1:0];
         end else begin
            cnt_in[a] = cnt_raw[a][SUM_W] ? {1'b1, {(CNT_W-1){1'b0}}} :
                                            {1'b0, {(CNT_W-1){1'b1}}};
         end
         dist_in[a] = DIST_W'(curoff[a]) - (DIST_W'(count_ff[a]) <<< FRAC_BITS);

         // Reverse hysteresis
         hold = (last_ff[a] == DIR_NEG && dist_ff[a] > 0 &&
                 dist_ff[a] < DIST_W'(HYST)) ||
                (last_ff[a] == DIR_POS && dist_ff[a] < 0 &&
                 dist_ff[a] > DIST_W'(-HYST));
         cntf_in[a] = hold ? count_ff[a] : cnt_ff[a];
         diff_in[a] = (CNT_W+1)'(cntf_in[a]) - (CNT_W+1)'(count_ff[a]);
         if (diff_in[a] > 0) begin
            dir_in[a] = DIR_POS;
         end else if (diff_in[a] < 0) begin
            dir_in[a] = DIR_NEG;
         end else begin
            dir_in[a] = DIR_NONE;
         end
         absd[a]     = (diff_in[a] < 0) ? -diff_in[a] : diff_in[a];
         steps_in[a] = (absd[a] > (CNT_W+1)'(STEP_CAP)) ? STEP_W'(STEP_CAP) :
                                                           absd[a][STEP_W-1:0];

         mag[a]    = (total_ff[a] < 0) ? -total_ff[a] : total_ff[a];
         key_of[a] = pos_ff[a] ? key_table_ff[16*a +: 8] : key_table_ff[16*a+8 +: 8];
         en[a]     = (key_of[a] != 8'd0) && (steps_ff[a] != '0);
      end
   end

   // Dominant axis pick, ties go to the lower axis
   always_comb begin
      priority if (mag[0] >= mag[1] && mag[0] >= mag[2]) begin
         pick    = 2'd0;
         mag_max = mag[0];
      end else if (mag[1] >= mag[2]) begin
         pick    = 2'd1;
         mag_max = mag[1];
      end else begin
         pick    = 2'd2;
         mag_max = mag[2];
      end
      lock_hit = (locked_ff == LOCK_NONE) && lock_en_ff && (mag_max >= SUM_W'(ONE));
   end

   // Emission selection: first axis with steps left and a nonzero key
   always_comb begin
      priority if (en[0]) begin
         sel      = 2'd0;
         later_en = en[1] || en[2];
      end else if (en[1]) begin
         sel      = 2'd1;
         later_en = en[2];
      end else begin
         sel      = 2'd2;
         later_en = 1'b0;
      end
      room_now  = (7'(n_ff) < 7'(PAIR_LIMIT)) && (7'(n_ff) + 7'd2 <= 7'(MAX_RESULTS));
      room_next = (7'(n_ff) + 7'd2 < 7'(PAIR_LIMIT)) &&
                  (7'(n_ff) + 7'd4 <= 7'(MAX_RESULTS));
      last_rel  = !room_next || ((steps_ff[sel] == STEP_W'(1)) && !later_en);
   end

   assign status.batch_end  = batch_end_ff;
   assign status.pair_avail = (en[0] || en[1] || en[2]) && room_now;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff[0]   <= '0;
         gain_ff[1]   <= '0;
         gain_ff[2]   <= '0;
         lock_en_ff   <= 1'b0;
         key_table_ff <= '0;
      end else if (csr_wen) begin
         unique case (csr_addr)
            REG_GAIN_X:    gain_ff[0]   <= csr_wdata[15:0];
            REG_GAIN_Y:    gain_ff[1]   <= csr_wdata[15:0];
            REG_GAIN_Z:    gain_ff[2]   <= csr_wdata[15:0];
            REG_LOCK_EN:   lock_en_ff   <= csr_wdata[0];
            REG_KEY_TABLE: key_table_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Axis state and sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            batch_ff[a] <= '0;
            total_ff[a] <= '0;
            count_ff[a] <= '0;
            first_ff[a] <= DIR_NONE;
            last_ff[a]  <= DIR_NONE;
            steps_ff[a] <= '0;
         end
         locked_ff    <= LOCK_NONE;
         batch_end_ff <= 1'b0;
         n_ff         <= '0;
      end else begin
         if (cmd.accept) begin
            batch_end_ff <= req_batch_end;
            if (req_restart) begin
               locked_ff <= LOCK_NONE;
            end
         end
         for (int a = 0; a < 3; a++) begin
            // Clear sums, counts and directions ahead of a restart item
            if (cmd.accept && req_restart) begin
               batch_ff[a] <= '0;
               total_ff[a] <= '0;
               count_ff[a] <= '0;
               first_ff[a] <= DIR_NONE;
               last_ff[a]  <= DIR_NONE;
            end
            if (cmd.acc && active[a]) begin
               batch_ff[a] <= acc_in[a];
            end
            // Fold batch into total, drop stale steps
            if (cmd.q1) begin
               batch_ff[a] <= '0;
               steps_ff[a] <= '0;
               if (active[a]) begin
                  total_ff[a] <= tot_in[a];
               end
            end
            if (cmd.q3 && active[a]) begin
               count_ff[a] <= cntf_in[a];
               if (first_ff[a] == DIR_NONE) begin
                  first_ff[a] <= dir_in[a];
               end
               last_ff[a]  <= dir_in[a];
               steps_ff[a] <= steps_in[a];
            end
            // Locking clears the other axes
            if (cmd.lock && lock_hit && (2'(a) != pick)) begin
               total_ff[a] <= '0;
               count_ff[a] <= '0;
               first_ff[a] <= DIR_NONE;
               last_ff[a]  <= DIR_NONE;
               steps_ff[a] <= '0;
            end
            if (cmd.load_rel && (2'(a) == sel)) begin
               steps_ff[a] <= steps_ff[a] - STEP_W'(1);
            end
         end
         if (cmd.lock && lock_hit) begin
            locked_ff <= pick + 2'd1;
         end
         if (cmd.q1) begin
            n_ff <= '0;
         end else if (cmd.load_rel) begin
            n_ff <= n_ff + N_W'(2);
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         interval_ff <= req_interval_us;
      end
      for (int a = 0; a < 3; a++) begin
         if (cmd.accept) begin
            prod1_ff[a] <= prod1_in[a];
         end
         if (cmd.mul2) begin
            prod2_ff[a] <= prod2_wide[a][SUM_W-1:0];
         end
         if (cmd.q2) begin
            cnt_ff[a]  <= cnt_in[a];
            dist_ff[a] <= dist_in[a];
         end
         if (cmd.q3) begin
            pos_ff[a] <= (dir_in[a] == DIR_POS);
         end
      end
      // Load key item, then its release item
      if (cmd.load_key) begin
         key_ff   <= key_of[sel];
         rlast_ff <= 1'b0;
      end else if (cmd.load_rel) begin
         key_ff   <= 8'd0;
         rlast_ff <= last_rel;
      end
   end

   assign rsp_key_code = key_ff;
   assign rsp_last     = rlast_ff;

endmodule

### hw/rtl/gyro_detent_encoder_axis_lock.sv
// Top level of the gyro detent encoder with axis lock.
// Sequence: a sample without batch end passes accept, second multiply and accumulate.
// A batch-end sample then runs quantize and lock, and a check; the first key item shows
// once the check finds a pair, and each key/release pair passes check, key and release.
// Input: a new sample is taken only when idle, never during quantize, lock or emission.
// Reset: synchronous, active high; clears configuration, sums, counts, directions and lock.
`timescale 1ns / 1ps

module gyro_detent_encoder_axis_lock (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wen,
   input  logic [gde_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [gde_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [15:0]             req_rate_x,
   input  logic signed [15:0]             req_rate_y,
   input  logic signed [15:0]             req_rate_z,
   input  logic [15:0]                    req_interval_us,
   input  logic                           req_batch_end,
   input  logic                           req_restart,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_key_code,
   output logic                           rsp_last
);
   import gde_pkg::*;

   gde_cmd_type    cmd;
   gde_status_type status;

   gde_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gde_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_wen         (csr_wen),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .req_rate_x      (req_rate_x),
      .req_rate_y      (req_rate_y),
      .req_rate_z      (req_rate_z),
      .req_interval_us (req_interval_us),
      .req_batch_end   (req_batch_end),
      .req_restart     (req_restart),
      .rsp_key_code    (rsp_key_code),
      .rsp_last        (rsp_last)
   );

`ifndef NO_ASSERTIONS
   // No input is taken while items are being emitted
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken during emission");

   // Every key item is followed by a release item
   a_key_then_release: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_key_code != 8'd0) |=>
      (rsp_valid && rsp_key_code == 8'd0))
      else $error("key item not followed by release");

   // A key item is never the final item of a batch
   a_key_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_key_code != 8'd0) |-> !rsp_last)
      else $error("key item flagged as last");

   // Nothing follows the final item of a batch
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> !rsp_valid)
      else $error("item after last");
`endif

endmodule
